[src/slex_pkg.sv]
// Package for the script lexer: transaction types, token kind codes,
// character constants and the keyword table. No dependencies.
package slex_pkg;

   // Width of byte offsets kept inside the scanner (8 to 32)
   localparam int unsigned OFFSET_BITS = 16;

   // Result queue depth and the room one input transaction may need
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned MAX_TOKENS = 3;

   // Input transaction
   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_marker;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [5:0]  token_kind;
      logic        error_kind;
      logic [15:0] lexeme_start;
      logic [15:0] lexeme_length;
      logic [15:0] line_number;
      logic        last_of_run;
   } rsp_type;

   // Scanner modes, one-hot
   typedef enum logic [8:0] {
      MODE_IDLE    = 9'b000000001,
      MODE_OP      = 9'b000000010,
      MODE_COMMENT = 9'b000000100,
      MODE_STR     = 9'b000001000,
      MODE_ESC     = 9'b000010000,
      MODE_INT     = 9'b000100000,
      MODE_DOT     = 9'b001000000,
      MODE_FRAC    = 9'b010000000,
      MODE_IDENT   = 9'b100000000
   } mode_type;

   // Operator waiting to see whether '=' or '/' follows
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_BANG    = 3'd1,
      OP_EQUAL   = 3'd2,
      OP_LESS    = 3'd3,
      OP_GREATER = 3'd4,
      OP_SLASH   = 3'd5
   } op_type;

   // Token kinds
   localparam logic [5:0] KIND_DOT        = 6'd8;
   localparam logic [5:0] KIND_PAIR_BASE  = 6'd12;
   localparam logic [5:0] KIND_BANG       = 6'd13;
   localparam logic [5:0] KIND_EQUAL      = 6'd15;
   localparam logic [5:0] KIND_LESS       = 6'd17;
   localparam logic [5:0] KIND_GREATER    = 6'd19;
   localparam logic [5:0] KIND_SLASH      = 6'd22;
   localparam logic [5:0] KIND_STRING     = 6'd23;
   localparam logic [5:0] KIND_NUMBER     = 6'd24;
   localparam logic [5:0] KIND_IDENT      = 6'd25;
   localparam logic [5:0] KIND_KEYWORD0   = 6'd26;
   localparam logic [5:0] KIND_EOF        = 6'd42;
   localparam logic [5:0] KIND_ERROR      = 6'd43;

   // Error kinds
   localparam logic ERR_UNEXPECTED   = 1'b0;
   localparam logic ERR_UNTERMINATED = 1'b1;

   // Characters
   localparam logic [7:0] CH_EQUAL     = "=";
   localparam logic [7:0] CH_SLASH     = "/";
   localparam logic [7:0] CH_BACKSLASH = "\\";
   localparam logic [7:0] CH_DQUOTE    = "\"";
   localparam logic [7:0] CH_SQUOTE    = "'";
   localparam logic [7:0] CH_NEWLINE   = "\n";
   localparam logic [7:0] CH_CR        = "\r";
   localparam logic [7:0] CH_TAB       = "\t";
   localparam logic [7:0] CH_SPACE     = " ";
   localparam logic [7:0] CH_BANG      = "!";
   localparam logic [7:0] CH_LESS      = "<";
   localparam logic [7:0] CH_GREATER   = ">";
   localparam logic [7:0] CH_PERIOD    = ".";
   localparam logic [7:0] CH_UNDERSCORE = "_";

   // Single-character punctuation, kind = position in this table
   localparam int unsigned NUM_PUNCT = 13;
   localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
      "(", ")", "{", "}", "[", "]", "$", ",", ".", "-", "+", ";", "*"
   };

   // Keywords, right-aligned bytes, kind = KIND_KEYWORD0 + position
   localparam int unsigned NUM_KEYWORDS = 16;
   localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
      48'h00000061_6e64,  // and
      48'h0063_6c617373,  // class
      48'h0000_656c7365,  // else
      48'h0066_616c7365,  // false
      48'h00000000_666e,  // fn
      48'h00000066_6f72,  // for
      48'h00000000_6966,  // if
      48'h0000_6e756c6c,  // null
      48'h00000000_6f72,  // or
      48'h0000_6563686f,  // echo
      48'h7265_7475726e,  // return
      48'h0073_75706572,  // super
      48'h0000_74686973,  // this
      48'h0000_74727565,  // true
      48'h0000006c_6574,  // let
      48'h0077_68696c65   // while
   };
   localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
      3'd3, 3'd5, 3'd4, 3'd5, 3'd2, 3'd3, 3'd2, 3'd4,
      3'd2, 3'd4, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

endpackage

[src/script_lexer.sv]
// Script lexer top level: streaming byte scanner and result queue.
// Depends on slex_pkg for transaction types, kind codes and keyword table.
//
// Usage:
//   req_*  : one source byte per transaction (or the end marker). A byte is
//            taken when req_valid is high and req_stall is low.
//   rsp_*  : tokens, one per transaction, taken when rsp_valid is high and
//            rsp_stall is low. last_of_run marks the final token caused by
//            one input transaction; a byte that finishes no token gives none.
//   csr_*  : writes the first line number; also loads the line counter.
//            csr_ready is always high.
// Order: an accepted byte is held in the input register and scanned there
//   once the queue has room; its tokens go into the result queue and show
//   on rsp_* in order. Throughput: one byte per cycle while req_stall is low.
//   The scan step is combinational; the 8-entry result queue drains one
//   token per cycle while rsp_stall is low, and the input register waits
//   (req_stall high) while fewer than three queue slots are free.
// Reset: scanner idle, offset 0, line counter 1, queue empty.
// A stalled receiver simply fills the queue and then stalls the sender.
module script_lexer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slex_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output slex_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import slex_pkg::*;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   typedef struct packed {
      logic       hit;
      logic [5:0] kind;
   } punct_type;

   // Input register
   logic                      in_valid_ff;
   req_type                   in_ff;

   // Scanner state
   mode_type                  mode_ff, mode_in;
   op_type                    pend_ff, pend_in;
   logic [OFFSET_BITS-1:0]    tb_ff, tb_in;
   logic [OFFSET_BITS-1:0]    pos_ff, pos_in;
   logic [15:0]               line_ff, line_in;
   logic [47:0]               wp_ff, wp_in;
   logic                      quote_ff, quote_in;

   // Result queue
   rsp_type                   queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, rd_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   // Step signals
   logic                      step_go;
   logic                      pop;
   logic [7:0]                cur_byte;
   logic [OFFSET_BITS-1:0]    span_cur;
   logic [OFFSET_BITS-1:0]    dot_at;
   logic [1:0]                fl_n;
   rsp_type                   fl_tok [2];
   logic [1:0]                tok_n;
   rsp_type                   tok [MAX_TOKENS];
   logic                      handled;
   punct_type                 punct;
   logic [7:0]                quote_char;

   // ---- helper functions ----

   function automatic logic [15:0] sat_out(input logic [OFFSET_BITS:0] v);
      logic [OFFSET_BITS+16:0] w;
      w = {16'b0, v};
      return (w > (OFFSET_BITS+17)'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic rsp_type make_tok(input logic [5:0] kind, input logic err,
                                        input logic [OFFSET_BITS-1:0] start,
                                        input logic [OFFSET_BITS:0] len,
                                        input logic [15:0] line);
      rsp_type t;
      t.token_kind    = kind;
      t.error_kind    = err;
      t.lexeme_start  = sat_out({1'b0, start});
      t.lexeme_length = sat_out(len);
      t.line_number   = line;
      t.last_of_run   = 1'b0;
      return t;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] from,
                                                   input logic [OFFSET_BITS-1:0] upto);
      return (upto >= from) ? upto - from : '0;
   endfunction

   function automatic logic [5:0] word_kind(input logic [47:0] wp, input logic [2:0] len);
      logic [47:0] mask;
      logic [5:0]  kind;
      mask = (48'h1 << {len, 3'b000}) - 48'h1;
      kind = KIND_IDENT;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (KW_LEN[k] == len && (wp & mask) == KW_TEXT[k])
            kind = KIND_KEYWORD0 + 6'(k);
      end
      return kind;
   endfunction

   function automatic logic [5:0] single_op_kind(input op_type p);
      logic [5:0] kind;
      case (p)
         OP_BANG:    kind = KIND_BANG;
         OP_EQUAL:   kind = KIND_EQUAL;
         OP_LESS:    kind = KIND_LESS;
         OP_GREATER: kind = KIND_GREATER;
         OP_SLASH:   kind = KIND_SLASH;
         default:    kind = 6'd0;
      endcase
      return kind;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDERSCORE;
   endfunction

   // ---- handshakes ----

   assign step_go   = in_valid_ff && (count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - MAX_TOKENS));
   assign req_stall = in_valid_ff && !step_go;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   // ---- token held by the current mode, ending before the current byte ----

   assign span_cur = span(tb_ff, pos_ff);
   assign dot_at   = (pos_ff != '0) ? pos_ff - 1'b1 : '0;

   always_comb begin
      fl_n      = 2'd0;
      fl_tok[0] = '0;
      fl_tok[1] = '0;
      case (mode_ff)
         MODE_OP: begin
            fl_tok[0] = make_tok(single_op_kind(pend_ff), 1'b0, tb_ff,
                                 (OFFSET_BITS+1)'(1), line_ff);
            fl_n = 2'd1;
         end
         MODE_INT, MODE_FRAC: begin
            fl_tok[0] = make_tok(KIND_NUMBER, 1'b0, tb_ff, {1'b0, span_cur}, line_ff);
            fl_n = 2'd1;
         end
         MODE_DOT: begin
            fl_tok[0] = make_tok(KIND_NUMBER, 1'b0, tb_ff,
                                 {1'b0, span(tb_ff, dot_at)}, line_ff);
            fl_tok[1] = make_tok(KIND_DOT, 1'b0, dot_at, (OFFSET_BITS+1)'(1), line_ff);
            fl_n = 2'd2;
         end
         MODE_IDENT: begin
            fl_tok[0] = make_tok((span_cur <= OFFSET_BITS'(6)) ?
                                 word_kind(wp_ff, span_cur[2:0]) : KIND_IDENT,
                                 1'b0, tb_ff, {1'b0, span_cur}, line_ff);
            fl_n = 2'd1;
         end
         default: begin
            fl_n = 2'd0;
         end
      endcase
   end

   // Punctuation lookup
   always_comb begin
      punct = '0;
      for (int i = 0; i < NUM_PUNCT; i++) begin
         if (cur_byte == PUNCT_CHARS[i]) begin
            punct.hit  = 1'b1;
            punct.kind = 6'(i);
         end
      end
   end

   assign cur_byte   = in_ff.source_byte;
   assign quote_char = quote_ff ? CH_SQUOTE : CH_DQUOTE;

   // ---- one scan step ----
   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      tb_in    = tb_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      wp_in    = wp_ff;
      quote_in = quote_ff;
      tok_n    = 2'd0;
      for (int i = 0; i < MAX_TOKENS; i++) tok[i] = '0;
      handled  = 1'b1;

      if (in_ff.end_marker) begin
         // End of source: close whatever is open, then EOF
         if (mode_ff == MODE_STR || mode_ff == MODE_ESC) begin
            tok[0] = make_tok(KIND_ERROR, ERR_UNTERMINATED, tb_ff, {1'b0, span_cur}, line_ff);
            tok_n  = 2'd1;
         end else if (mode_ff != MODE_COMMENT) begin
            tok[0] = fl_tok[0];
            tok[1] = fl_tok[1];
            tok_n  = fl_n;
         end
         tok[tok_n] = make_tok(KIND_EOF, 1'b0, pos_ff, '0, line_ff);
         tok_n   = tok_n + 2'd1;
         mode_in = MODE_IDLE;
         pend_in = OP_NONE;
         wp_in   = '0;
      end else begin
         // Feed the byte to the open token
         case (mode_ff)
            MODE_OP: begin
               if (cur_byte == CH_EQUAL && pend_ff >= OP_BANG && pend_ff <= OP_GREATER) begin
                  tok[0]  = make_tok(KIND_PAIR_BASE + {2'b00, pend_ff, 1'b0}, 1'b0, tb_ff,
                                     (OFFSET_BITS+1)'(2), line_ff);
                  tok_n   = 2'd1;
                  mode_in = MODE_IDLE;
                  pend_in = OP_NONE;
               end else if (cur_byte == CH_SLASH && pend_ff == OP_SLASH) begin
                  mode_in = MODE_COMMENT;
                  pend_in = OP_NONE;
               end else begin
                  handled = 1'b0;
               end
            end
            MODE_COMMENT: begin
               if (cur_byte == CH_NEWLINE) begin
                  mode_in = MODE_IDLE;
                  handled = 1'b0;
               end
            end
            MODE_STR: begin
               if (cur_byte == quote_char) begin
                  tok[0]  = make_tok(KIND_STRING, 1'b0, tb_ff,
                                     {1'b0, span_cur} + (OFFSET_BITS+1)'(1), line_ff);
                  tok_n   = 2'd1;
                  mode_in = MODE_IDLE;
               end else if (cur_byte == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else if (cur_byte == CH_NEWLINE) begin
                  line_in = (line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_STR;
            end
            MODE_INT: begin
               if (cur_byte == CH_PERIOD) mode_in = MODE_DOT;
               else if (!is_digit(cur_byte)) handled = 1'b0;
            end
            MODE_DOT: begin
               if (is_digit(cur_byte)) mode_in = MODE_FRAC;
               else handled = 1'b0;
            end
            MODE_FRAC: begin
               if (!is_digit(cur_byte)) handled = 1'b0;
            end
            MODE_IDENT: begin
               if (is_alpha(cur_byte) || is_digit(cur_byte)) wp_in = {wp_ff[39:0], cur_byte};
               else handled = 1'b0;
            end
            default: begin
               mode_in = MODE_IDLE;
               handled = 1'b0;
            end
         endcase

         // Byte not taken by the open token: close it and start a new one
         if (!handled) begin
            if (mode_ff != MODE_COMMENT) begin
               tok[0]  = fl_tok[0];
               tok[1]  = fl_tok[1];
               tok_n   = fl_n;
               mode_in = MODE_IDLE;
               pend_in = OP_NONE;
            end
            if (punct.hit) begin
               tok[tok_n] = make_tok(punct.kind, 1'b0, pos_ff, (OFFSET_BITS+1)'(1), line_ff);
               tok_n      = tok_n + 2'd1;
            end else begin
               tb_in = pos_ff;
               case (cur_byte)
                  CH_BANG:    begin mode_in = MODE_OP;  pend_in = OP_BANG;    end
                  CH_EQUAL:   begin mode_in = MODE_OP;  pend_in = OP_EQUAL;   end
                  CH_LESS:    begin mode_in = MODE_OP;  pend_in = OP_LESS;    end
                  CH_GREATER: begin mode_in = MODE_OP;  pend_in = OP_GREATER; end
                  CH_SLASH:   begin mode_in = MODE_OP;  pend_in = OP_SLASH;   end
                  CH_DQUOTE:  begin mode_in = MODE_STR; quote_in = 1'b0;      end
                  CH_SQUOTE:  begin mode_in = MODE_STR; quote_in = 1'b1;      end
                  CH_SPACE, CH_CR, CH_TAB: begin
                     mode_in = MODE_IDLE;
                  end
                  CH_NEWLINE: begin
                     line_in = (line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;
                  end
                  default: begin
                     if (is_digit(cur_byte)) begin
                        mode_in = MODE_INT;
                     end else if (is_alpha(cur_byte)) begin
                        mode_in = MODE_IDENT;
                        wp_in   = {40'b0, cur_byte};
                     end else begin
                        tok[tok_n] = make_tok(KIND_ERROR, ERR_UNEXPECTED, pos_ff,
                                              (OFFSET_BITS+1)'(1), line_ff);
                        tok_n      = tok_n + 2'd1;
                     end
                  end
               endcase
            end
         end

         pos_in = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;
      end

      // Mark the final token of this transaction
      if (tok_n != 2'd0) tok[tok_n - 2'd1].last_of_run = 1'b1;
   end

   // Scanner state registers; a configuration write reloads the line counter
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= OP_NONE;
         tb_ff    <= '0;
         pos_ff   <= '0;
         line_ff  <= 16'd1;
         wp_ff    <= '0;
         quote_ff <= 1'b0;
      end else begin
         if (step_go) begin
            mode_ff  <= mode_in;
            pend_ff  <= pend_in;
            tb_ff    <= tb_in;
            pos_ff   <= pos_in;
            wp_ff    <= wp_in;
            quote_ff <= quote_in;
         end
         if (csr_valid && csr_ready) begin
            line_ff <= csr_data;
         end else if (step_go) begin
            line_ff <= line_in;
         end
      end
   end

   // Result queue: up to three writes, one read per cycle
   assign count_in = count_ff + (step_go ? {{(QUEUE_PTR_BITS-1){1'b0}}, tok_n} : '0)
                     - {{QUEUE_PTR_BITS{1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (step_go) wr_ff <= wr_ff + {{(QUEUE_PTR_BITS-2){1'b0}}, tok_n};
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         for (int i = 0; i < MAX_TOKENS; i++) begin
            if (2'(i) < tok_n) queue_ff[wr_ff + QUEUE_PTR_BITS'(i)] <= tok[i];
         end
      end
   end

   // ---- assertions ----

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_mode_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(mode_ff))
      else $error("scanner mode not one-hot");

   a_eof_emits: assert property (@(posedge clock) disable iff (reset)
      step_go && in_ff.end_marker |-> tok_n != 2'd0 && tok[tok_n - 2'd1].token_kind == KIND_EOF)
      else $error("end marker without EOF token");

   a_eof_idle: assert property (@(posedge clock) disable iff (reset)
      step_go && in_ff.end_marker |=> mode_ff == MODE_IDLE && pend_ff == OP_NONE)
      else $error("scanner not idle after end marker");

   a_pos_monotonic: assert property (@(posedge clock) disable iff (reset)
      step_go |=> pos_ff >= $past(pos_ff))
      else $error("byte offset went backwards");

endmodule

[verif/tb_script_lexer.sv]
// Self-checking testbench for script_lexer: drives source bytes, predicts tokens
// in-line and compares every token the block emits. Depends on slex_pkg.
module tb_script_lexer;
   import slex_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PRINT_CAP = 40;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [15:0] csr_data;

   script_lexer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Character sets used by the predictor and the stimulus
   string punct_text = "(){}[]$,.-+;*";
   string op_text = "!=<>/";
   string space_text = " \t\r\n";
   string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string kw_names [16] = '{
      "and", "class", "else", "false", "fn", "for", "if", "null",
      "or", "echo", "return", "super", "this", "true", "let", "while"
   };

   // Scanner shadow state
   logic [15:0] line_cnt;
   logic [OFFSET_BITS-1:0] tok_begin;
   logic [OFFSET_BITS-1:0] byte_pos;
   mode_type scan_state;
   op_type held_op;
   logic [47:0] word_tail;
   logic quote_single;

   rsp_type token_q [$];      // tokens still owed by the block
   req_type source_q [$];     // bytes waiting to be sent
   int step_tokens;
   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int cycle_count;

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] clip16(longint unsigned v);
      return (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic longint unsigned span(longint unsigned from, longint unsigned upto);
      return (upto >= from) ? upto - from : 0;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDERSCORE;
   endfunction

   function automatic void push_token(logic [5:0] kind, logic err, longint unsigned start,
                                      longint unsigned len);
      rsp_type t;
      if (step_tokens >= MAX_TOKENS) return;
      t.token_kind = kind;
      t.error_kind = err;
      t.lexeme_start = clip16(start);
      t.lexeme_length = clip16(len);
      t.line_number = line_cnt;
      t.last_of_run = 1'b0;
      token_q.push_back(t);
      step_tokens++;
   endfunction

   // Emit whatever token the current mode holds, ending just before byte_pos
   function automatic void flush_open();
      logic [5:0] kind;
      longint unsigned dot_at;
      int len;
      bit same;
      case (scan_state)
         MODE_OP: begin
            case (held_op)
               OP_BANG:    kind = KIND_BANG;
               OP_EQUAL:   kind = KIND_EQUAL;
               OP_LESS:    kind = KIND_LESS;
               OP_GREATER: kind = KIND_GREATER;
               default:    kind = KIND_SLASH;
            endcase
            push_token(kind, 1'b0, tok_begin, 1);
         end
         MODE_INT, MODE_FRAC: push_token(KIND_NUMBER, 1'b0, tok_begin, span(tok_begin, byte_pos));
         MODE_DOT: begin
            dot_at = (byte_pos > 0) ? byte_pos - 1 : 0;
            push_token(KIND_NUMBER, 1'b0, tok_begin, span(tok_begin, dot_at));
            push_token(KIND_DOT, 1'b0, dot_at, 1);
         end
         MODE_IDENT: begin
            len = int'(span(tok_begin, byte_pos));
            kind = KIND_IDENT;
            // keyword match on the kept tail bytes
            if (len <= 6) begin
               for (int k = 0; k < 16; k++) begin
                  if (kind == KIND_IDENT && kw_names[k].len() == len) begin
                     same = 1'b1;
                     for (int i = 0; i < len; i++)
                        if (word_tail[8*(len-1-i) +: 8] != kw_names[k][i]) same = 1'b0;
                     if (same) kind = KIND_KEYWORD0 + 6'(k);
                  end
               end
            end
            push_token(kind, 1'b0, tok_begin, len);
         end
         default: ;
      endcase
      scan_state = MODE_IDLE;
      held_op = OP_NONE;
   endfunction

   // Offer a byte to the open token; 0 means it must start a new one
   function automatic bit extend_token(logic [7:0] b);
      case (scan_state)
         MODE_OP: begin
            if (b == CH_EQUAL && held_op >= OP_BANG && held_op <= OP_GREATER) begin
               push_token(KIND_PAIR_BASE + {held_op, 1'b0}, 1'b0, tok_begin, 2);
               scan_state = MODE_IDLE;
               held_op = OP_NONE;
               return 1'b1;
            end
            if (b == CH_SLASH && held_op == OP_SLASH) begin
               scan_state = MODE_COMMENT;
               held_op = OP_NONE;
               return 1'b1;
            end
            flush_open();
            return 1'b0;
         end
         MODE_COMMENT: begin
            if (b == CH_NEWLINE) begin
               scan_state = MODE_IDLE;
               return 1'b0;
            end
            return 1'b1;
         end
         MODE_STR: begin
            if (b == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
               push_token(KIND_STRING, 1'b0, tok_begin, span(tok_begin, byte_pos) + 1);
               scan_state = MODE_IDLE;
            end else if (b == CH_BACKSLASH) begin
               scan_state = MODE_ESC;
            end else if (b == CH_NEWLINE && line_cnt != 16'hFFFF) begin
               line_cnt++;
            end
            return 1'b1;
         end
         MODE_ESC: begin
            scan_state = MODE_STR;
            return 1'b1;
         end
         MODE_INT: begin
            if (is_digit(b)) return 1'b1;
            if (b == CH_PERIOD) begin
               scan_state = MODE_DOT;
               return 1'b1;
            end
            flush_open();
            return 1'b0;
         end
         MODE_DOT, MODE_FRAC: begin
            if (is_digit(b)) begin
               scan_state = MODE_FRAC;
               return 1'b1;
            end
            flush_open();
            return 1'b0;
         end
         MODE_IDENT: begin
            if (is_alpha(b) || is_digit(b)) begin
               word_tail = {word_tail[39:0], b};
               return 1'b1;
            end
            flush_open();
            return 1'b0;
         end
         default: begin
            scan_state = MODE_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void start_token(logic [7:0] b);
      for (int i = 0; i < punct_text.len(); i++) begin
         if (b == punct_text[i]) begin
            push_token(6'(i), 1'b0, byte_pos, 1);
            return;
         end
      end
      tok_begin = byte_pos;
      case (b)
         CH_BANG:    begin scan_state = MODE_OP; held_op = OP_BANG; end
         CH_EQUAL:   begin scan_state = MODE_OP; held_op = OP_EQUAL; end
         CH_LESS:    begin scan_state = MODE_OP; held_op = OP_LESS; end
         CH_GREATER: begin scan_state = MODE_OP; held_op = OP_GREATER; end
         CH_SLASH:   begin scan_state = MODE_OP; held_op = OP_SLASH; end
         CH_DQUOTE:  begin scan_state = MODE_STR; quote_single = 1'b0; end
         CH_SQUOTE:  begin scan_state = MODE_STR; quote_single = 1'b1; end
         CH_SPACE, CH_CR, CH_TAB: ;
         CH_NEWLINE: if (line_cnt != 16'hFFFF) line_cnt++;
         default: begin
            if (is_digit(b)) begin
               scan_state = MODE_INT;
            end else if (is_alpha(b)) begin
               scan_state = MODE_IDENT;
               word_tail = {40'd0, b};
            end else begin
               push_token(KIND_ERROR, ERR_UNEXPECTED, byte_pos, 1);
            end
         end
      endcase
   endfunction

   // Tokens caused by one accepted transaction
   function automatic void scan_item(req_type it);
      rsp_type t;
      step_tokens = 0;
      if (it.end_marker) begin
         if (scan_state == MODE_STR || scan_state == MODE_ESC)
            push_token(KIND_ERROR, ERR_UNTERMINATED, tok_begin, span(tok_begin, byte_pos));
         else if (scan_state != MODE_COMMENT)
            flush_open();
         push_token(KIND_EOF, 1'b0, byte_pos, 0);
         scan_state = MODE_IDLE;
         held_op = OP_NONE;
         word_tail = '0;
      end else begin
         if (!extend_token(it.source_byte)) start_token(it.source_byte);
         if (byte_pos != POS_MAX) byte_pos++;
      end
      if (step_tokens > 0) begin
         t = token_q.pop_back();
         t.last_of_run = 1'b1;
         token_q.push_back(t);
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report(string msg);
      if (mismatches < PRINT_CAP) $display("[%0d] mismatch: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_byte(logic [7:0] b);
      req_type r;
      r.source_byte = b;
      r.end_marker = 1'b0;
      source_q.push_back(r);
   endtask

   task automatic add_end();
      req_type r;
      r.source_byte = 8'($urandom_range(255));
      r.end_marker = 1'b1;
      source_q.push_back(r);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // One well-formed lexeme with random content, some noise, or an end marker
   task automatic add_fragment();
      logic [7:0] q;
      logic [7:0] op;
      int n;
      case ($urandom_range(10))
         0: add_byte(punct_text[$urandom_range(punct_text.len() - 1)]);
         1: begin
            op = op_text[$urandom_range(op_text.len() - 1)];
            add_byte(op);
            if ($urandom_range(1)) add_byte(CH_EQUAL);
         end
         2: begin
            repeat ($urandom_range(3, 1)) add_byte(8'("0" + $urandom_range(9)));
            if ($urandom_range(1)) begin
               add_byte(CH_PERIOD);
               repeat ($urandom_range(2)) add_byte(8'("0" + $urandom_range(9)));
            end
         end
         3: begin
            add_text(kw_names[$urandom_range(15)]);
            if ($urandom_range(3) == 0) add_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
         end
         4: begin
            add_byte(word_chars[$urandom_range(52)]);
            repeat ($urandom_range(8)) add_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
         end
         5: begin
            // string, sometimes left open up to the end marker
            q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
            add_byte(q);
            n = $urandom_range(5);
            repeat (n) begin
               case ($urandom_range(4))
                  0: add_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
                  1: begin
                     add_byte(CH_BACKSLASH);
                     case ($urandom_range(3))
                        0: add_byte(q);
                        1: add_byte(CH_NEWLINE);
                        2: add_byte(CH_BACKSLASH);
                        default: add_byte(8'($urandom_range(255)));
                     endcase
                  end
                  2: add_byte(CH_NEWLINE);
                  3: add_byte(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                  default: add_byte(8'($urandom_range(255)));
               endcase
            end
            if ($urandom_range(7) != 0) add_byte(q);
            else add_end();
         end
         6: begin
            add_text("//");
            repeat ($urandom_range(4)) add_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
            if ($urandom_range(5) != 0) add_byte(CH_NEWLINE);
            else add_end();
         end
         7: add_byte(space_text[$urandom_range(3)]);
         8, 9: add_byte(8'($urandom_range(255)));
         default: add_end();
      endcase
   endtask

   task automatic add_random(int items);
      int goal;
      goal = source_q.size() + items;
      while (source_q.size() < goal) begin
         add_fragment();
         if ($urandom_range(1)) add_byte(space_text[$urandom_range(3)]);
      end
      add_end();
   endtask

   task automatic write_first_line(logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (source_q.size() != 0 || req_valid || token_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- clock

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         line_cnt = 16'd1;
         tok_begin = '0;
         byte_pos = '0;
         scan_state = MODE_IDLE;
         held_op = OP_NONE;
         word_tail = '0;
         quote_single = 1'b0;
         token_q.delete();
      end else begin
         // register write also reloads the line counter
         if (csr_valid && csr_ready) begin
            line_cnt = csr_data;
         end
         if (req_valid && !req_stall) scan_item(req_data);
         // present the next transaction once the current one is taken
         if (!req_valid || !req_stall) begin
            if (source_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= source_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (token_q.size() == 0) begin
               report($sformatf("token kind %0d with none expected", rsp_data.token_kind));
            end else begin
               want = token_q.pop_front();
               check_field("token_kind", rsp_data.token_kind, want.token_kind);
               check_field("error_kind", rsp_data.error_kind, want.error_kind);
               check_field("lexeme_start", rsp_data.lexeme_start, want.lexeme_start);
               check_field("lexeme_length", rsp_data.lexeme_length, want.lexeme_length);
               check_field("line_number", rsp_data.line_number, want.line_number);
               check_field("last_of_run", rsp_data.last_of_run, want.last_of_run);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      mismatches = 0;
      send_idle_pct = 19;
      recv_idle_pct = 59;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: fraction, keyword, pair operators !=, <= and >=, number then dot,
      // bad bytes at both ends, newline, string left open in an escape,
      // number then dot at the end marker, comment at the end marker
      add_text("9.5if!=<=>==1.z");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_text("\n'a\\");
      add_end();
      add_text("7.");
      add_end();
      add_text("//");
      add_end();
      wait_drained();

      // Lowest first line
      write_first_line(16'd0);
      add_random(25);
      wait_drained();

      // Line counter runs into saturation
      send_idle_pct = 59;
      recv_idle_pct = 19;
      write_first_line(16'd65533);
      add_random(25);
      wait_drained();

      // Mid value, no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_first_line(16'($urandom_range(65532, 2)));
      add_random(25);
      wait_drained();

      // Highest first line
      write_first_line(16'hFFFF);
      add_random(25);
      wait_drained();

      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/slex_pkg.sv
src/script_lexer.sv
verif/tb_script_lexer.sv
